// ===== sv/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the status line parser
// Frame kinds, result and control structs, keyword patterns and the
// small character helpers used by the scan.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Keyword patterns, first character in the low byte
    localparam logic [39:0] KW_PONG  = 40'h00_47_4E_4F_50;
    localparam logic [39:0] KW_BUSY  = 40'h00_59_53_55_42;
    localparam logic [39:0] KW_READY = 40'h59_44_41_45_52;
    localparam logic [39:0] KW_OK    = 40'h00_00_00_4B_4F;
    localparam logic [39:0] KW_ERR   = 40'h00_00_52_52_45;
    localparam logic [39:0] KW_ADC   = 40'h00_00_43_44_41;
    localparam logic [39:0] KW_POS   = 40'h00_00_53_4F_50;
    localparam logic [39:0] KW_LIM   = 40'h00_00_4D_49_4C;
    localparam logic [39:0] KW_DBG   = 40'h00_00_47_42_44;

    localparam int          LEAD_CHARS     = 5;
    localparam logic [2:0]  TOKENS_NUMERIC = 3'd5;
    localparam logic [2:0]  TOKEN_CAP      = 3'd6;
    localparam logic [2:0]  LENGTH_CAP     = 3'd7;
    localparam logic [35:0] MAG_LIMIT      = 36'h0_8000_0000;

    typedef enum logic [3:0] {
        KIND_UNKNOWN = 4'd0,
        KIND_OK      = 4'd1,
        KIND_ERROR   = 4'd2,
        KIND_PONG    = 4'd3,
        KIND_BUSY    = 4'd4,
        KIND_READY   = 4'd5,
        KIND_ADC     = 4'd6,
        KIND_POS     = 4'd7,
        KIND_LIM     = 4'd8,
        KIND_DBG     = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [3:0][31:0] value;
    } frame_t;

    typedef struct packed {
        logic       take;
        logic [7:0] ch;
    } scan_in_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // First token starts with the n characters of kw
    function automatic logic has_prefix(
        input logic [39:0] lc,
        input logic [2:0]  tl,
        input logic [39:0] kw,
        input logic [2:0]  n
    );
        logic ok;
        ok = (tl >= n);
        for (int i = 0; i < LEAD_CHARS; i++)
        begin
            if ((3'(i) < n) && (lc[8*i +: 8] != kw[8*i +: 8]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== sv/ascii_status_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_status_line_parser_unit: text status line parser
// Input channel line_valid/line_stall/line_byte takes one character per
// transaction. A line feed ends the line and yields one frame on the
// output channel frame_valid/frame_stall with frame_kind and four values;
// every other byte yields nothing.
// Throughput: one byte per cycle while no line feed is held. A byte waits
// in the input register, then the line scan updates its state; a line
// feed loads the frame into the result register, from which the frame
// shows once its line feed has passed the input register.
// While a frame waits under frame_stall, ordinary bytes keep flowing;
// only a following line feed holds in the input register and raises
// line_stall until the waiting frame is taken.
// Reset clears the line state and both valid flags; a line starts empty.
// ----------------------------------------------------------------------------
module ascii_status_line_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               line_valid,
    output logic               line_stall,
    input  logic [7:0]         line_byte,
    output logic               frame_valid,
    input  logic               frame_stall,
    output logic [3:0]         frame_kind,
    output logic signed [31:0] value_first,
    output logic signed [31:0] value_second,
    output logic signed [31:0] value_third,
    output logic signed [31:0] value_fourth
);

    logic              in_full;
    logic [7:0]        in_data;
    logic              take;
    logic              emit;
    asp_pkg::scan_in_t scan_in;
    asp_pkg::frame_t   frame;
    asp_pkg::frame_t   frame_q;

    asp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_byte  (line_byte),
        .line_stall (line_stall),
        .take       (take),
        .full       (in_full),
        .data       (in_data)
    );

    // Hold a line feed while the result register cannot take its frame
    assign take = in_full && ((in_data != asp_pkg::CHAR_LF) || !frame_valid || !frame_stall);
    assign emit = take && (in_data == asp_pkg::CHAR_LF);

    assign scan_in.take = take;
    assign scan_in.ch   = in_data;

    asp_line_scan u_line_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_in),
        .frame   (frame)
    );

    asp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (emit),
        .d           (frame),
        .frame_stall (frame_stall),
        .valid       (frame_valid),
        .q           (frame_q)
    );

    assign frame_kind   = frame_q.kind;
    assign value_first  = frame_q.value[0];
    assign value_second = frame_q.value[1];
    assign value_third  = frame_q.value[2];
    assign value_fourth = frame_q.value[3];

endmodule

// ===== sv/asp_in_reg.sv =====
// ----------------------------------------------------------------------------
// asp_in_reg: input register of the status line parser
// Holds one accepted byte until the line scan takes it.
// ----------------------------------------------------------------------------
module asp_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_valid,
    input  logic [7:0] line_byte,
    output logic       line_stall,
    input  logic       take,
    output logic       full,
    output logic [7:0] data
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] data_reg;
    logic       load;

    // Stall only while a byte is held and not taken this cycle
    assign line_stall = full_reg && !take;
    assign load       = line_valid && !line_stall;

    always_comb
    begin
        full_next = full_reg;
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Capture the payload of each transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= line_byte;
        end
    end

    assign full = full_reg;
    assign data = data_reg;

endmodule

// ===== sv/asp_line_scan.sv =====
// ----------------------------------------------------------------------------
// asp_line_scan: per-line tokenizer and classifier
// Updates the line state for one byte per cycle and forms the frame
// that a line feed completes.
// ----------------------------------------------------------------------------
module asp_line_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  asp_pkg::scan_in_t scan_in,
    output asp_pkg::frame_t   frame
);

    logic [39:0]      lc_reg,      lc_next;
    logic [2:0]       tl_reg,      tl_next;
    logic             started_reg, started_next;
    logic [2:0]       tc_reg,      tc_next;
    logic             inside_reg,  inside_next;
    logic             neg_reg,     neg_next;
    logic             hd_reg,      hd_next;
    logic             de_reg,      de_next;
    logic             ovf_reg,     ovf_next;
    logic [31:0]      mag_reg,     mag_next;
    logic [3:0][31:0] res_reg,     res_next;
    logic             failed_reg,  failed_next;

    logic [7:0]       ch;
    logic             is_lf;
    logic             is_sp;
    logic             first;
    logic [2:0]       tc_new;
    logic             neg_b;
    logic             hd_b;
    logic             de_b;
    logic             ovf_b;
    logic [31:0]      mag_b;
    logic             is_digit;
    logic [35:0]      prod;
    logic [31:0]      tok_val;
    logic             tok_bad;
    logic             fin_slot;
    logic [1:0]       fin_idx;
    logic [3:0][31:0] fin_res;
    logic             fin_failed;
    logic             single;
    asp_pkg::kind_t   kind_pre;
    asp_pkg::kind_t   kind;
    logic             numeric;

    assign ch    = scan_in.ch;
    assign is_lf = (ch == asp_pkg::CHAR_LF);
    assign is_sp = asp_pkg::is_space(ch);

    // Close the current token: store its value or flag the line
    assign tok_val  = neg_reg ? (32'd0 - mag_reg) : mag_reg;
    assign tok_bad  = !hd_reg || ovf_reg || (!neg_reg && mag_reg[31]);
    assign fin_slot = inside_reg && (tc_reg >= 3'd2) && (tc_reg <= asp_pkg::TOKENS_NUMERIC);
    assign fin_idx  = 2'(tc_reg - 3'd2);

    always_comb
    begin
        fin_res    = res_reg;
        fin_failed = failed_reg;
        if (fin_slot)
        begin
            if (tok_bad)
            begin
                fin_failed = 1'b1;
            end
            else
            begin
                fin_res[fin_idx] = tok_val;
            end
        end
    end

    // Token scan fields as seen by a non-space byte
    assign first    = !inside_reg;
    assign tc_new   = !first ? tc_reg :
                      ((tc_reg == asp_pkg::TOKEN_CAP) ? tc_reg : tc_reg + 3'd1);
    assign neg_b    = first ? 1'b0  : neg_reg;
    assign hd_b     = first ? 1'b0  : hd_reg;
    assign de_b     = first ? 1'b0  : de_reg;
    assign ovf_b    = first ? 1'b0  : ovf_reg;
    assign mag_b    = first ? 32'd0 : mag_reg;
    assign is_digit = (ch >= asp_pkg::CHAR_ZERO) && (ch <= asp_pkg::CHAR_NINE);
    assign prod     = ({4'd0, mag_b} << 3) + ({4'd0, mag_b} << 1) + {32'd0, ch[3:0]};

    // Advance the line state
    always_comb
    begin
        lc_next      = lc_reg;
        tl_next      = tl_reg;
        started_next = started_reg;
        tc_next      = tc_reg;
        inside_next  = inside_reg;
        neg_next     = neg_reg;
        hd_next      = hd_reg;
        de_next      = de_reg;
        ovf_next     = ovf_reg;
        mag_next     = mag_reg;
        res_next     = res_reg;
        failed_next  = failed_reg;
        if (scan_in.take)
        begin
            if (is_lf)
            begin
                lc_next      = '0;
                tl_next      = '0;
                started_next = 1'b0;
                tc_next      = '0;
                inside_next  = 1'b0;
                neg_next     = 1'b0;
                hd_next      = 1'b0;
                de_next      = 1'b0;
                ovf_next     = 1'b0;
                mag_next     = '0;
                res_next     = '0;
                failed_next  = 1'b0;
            end
            else if (is_sp)
            begin
                if (inside_reg)
                begin
                    inside_next = 1'b0;
                    res_next    = fin_res;
                    failed_next = fin_failed;
                end
            end
            else
            begin
                inside_next  = 1'b1;
                started_next = 1'b1;
                tc_next      = tc_new;
                neg_next     = neg_b;
                hd_next      = hd_b;
                de_next      = de_b;
                ovf_next     = ovf_b;
                mag_next     = mag_b;
                if (tc_new == 3'd1)
                begin
                    for (int i = 0; i < asp_pkg::LEAD_CHARS; i++)
                    begin
                        if (tl_reg == 3'(i))
                        begin
                            lc_next[8*i +: 8] = ch;
                        end
                    end
                    if (tl_reg != asp_pkg::LENGTH_CAP)
                    begin
                        tl_next = tl_reg + 3'd1;
                    end
                end
                else if ((tc_new <= asp_pkg::TOKENS_NUMERIC) && !de_b)
                begin
                    if (is_digit)
                    begin
                        hd_next = 1'b1;
                        if (!ovf_b)
                        begin
                            if (prod > asp_pkg::MAG_LIMIT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = prod[31:0];
                            end
                        end
                    end
                    else if (first && ((ch == asp_pkg::CHAR_PLUS) ||
                                       (ch == asp_pkg::CHAR_MINUS)))
                    begin
                        neg_next = (ch == asp_pkg::CHAR_MINUS);
                    end
                    else
                    begin
                        de_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg      <= '0;
            tl_reg      <= '0;
            started_reg <= 1'b0;
            tc_reg      <= '0;
            inside_reg  <= 1'b0;
            neg_reg     <= 1'b0;
            hd_reg      <= 1'b0;
            de_reg      <= 1'b0;
            ovf_reg     <= 1'b0;
            mag_reg     <= '0;
            res_reg     <= '0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            lc_reg      <= lc_next;
            tl_reg      <= tl_next;
            started_reg <= started_next;
            tc_reg      <= tc_next;
            inside_reg  <= inside_next;
            neg_reg     <= neg_next;
            hd_reg      <= hd_next;
            de_reg      <= de_next;
            ovf_reg     <= ovf_next;
            mag_reg     <= mag_next;
            res_reg     <= res_next;
            failed_reg  <= failed_next;
        end
    end

    // Classify the line as it stands at the line feed
    assign single = (tc_reg == 3'd1);

    always_comb
    begin
        if (!started_reg)
            kind_pre = asp_pkg::KIND_UNKNOWN;
        else if (single && (tl_reg == 3'd4) &&
                 asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_PONG, 3'd4))
            kind_pre = asp_pkg::KIND_PONG;
        else if (single && (tl_reg == 3'd4) &&
                 asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_BUSY, 3'd4))
            kind_pre = asp_pkg::KIND_BUSY;
        else if (single && (tl_reg == 3'd5) &&
                 asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_READY, 3'd5))
            kind_pre = asp_pkg::KIND_READY;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_OK, 3'd2))
            kind_pre = asp_pkg::KIND_OK;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_ERR, 3'd3))
            kind_pre = asp_pkg::KIND_ERROR;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_ADC, 3'd3))
            kind_pre = asp_pkg::KIND_ADC;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_POS, 3'd3))
            kind_pre = asp_pkg::KIND_POS;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_LIM, 3'd3))
            kind_pre = asp_pkg::KIND_LIM;
        else if (asp_pkg::has_prefix(lc_reg, tl_reg, asp_pkg::KW_DBG, 3'd3))
            kind_pre = asp_pkg::KIND_DBG;
        else
            kind_pre = asp_pkg::KIND_UNKNOWN;
    end

    // Numeric frames need exactly five tokens, a bare keyword and valid numbers
    always_comb
    begin
        kind    = kind_pre;
        numeric = 1'b0;
        if ((kind_pre == asp_pkg::KIND_ADC) || (kind_pre == asp_pkg::KIND_POS) ||
            (kind_pre == asp_pkg::KIND_LIM))
        begin
            if ((tc_reg != asp_pkg::TOKENS_NUMERIC) || (tl_reg != 3'd3) || fin_failed)
            begin
                kind = asp_pkg::KIND_UNKNOWN;
            end
            else
            begin
                numeric = 1'b1;
            end
        end
    end

    assign frame.kind  = kind;
    assign frame.value = numeric ? fin_res : '0;

endmodule

// ===== sv/asp_out_reg.sv =====
// ----------------------------------------------------------------------------
// asp_out_reg: result register of the status line parser
// Holds one frame until the receiver takes the transaction.
// ----------------------------------------------------------------------------
module asp_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  asp_pkg::frame_t d,
    input  logic            frame_stall,
    output logic            valid,
    output asp_pkg::frame_t q
);

    logic            valid_reg;
    logic            valid_next;
    asp_pkg::frame_t q_reg;

    // Set on a new frame, drop once the transaction completes
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !frame_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= d;
        end
    end

    assign valid = valid_reg;
    assign q     = q_reg;

endmodule

// ===== test/ascii_status_line_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_status_line_parser_unit_tb: self-checking bench of the status line parser
// Streams text bytes into the parser and predicts each frame that a line
// feed produces. Each frame is checked field by field against the oldest
// prediction. The run starts with hand-written lines that cover the corner
// cases, then adds random lines in phases with varied sender and receiver
// pacing, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module ascii_status_line_parser_unit_tb;

    localparam int unsigned PHASE_BYTES = 370;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned END_CYCLES  = 8;

    typedef enum logic [2:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH,
        PACE_HOLD
    } pace_t;

    typedef struct packed {
        asp_pkg::kind_t   kind;
        logic [3:0][31:0] vals;
    } line_frame_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               line_valid  = 1'b0;
    logic               line_stall;
    logic [7:0]         line_byte   = 8'h00;
    logic               frame_valid;
    logic               frame_stall = 1'b0;
    logic [3:0]         frame_kind;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic signed [31:0] value_third;
    logic signed [31:0] value_fourth;

    pace_t       pace       = PACE_FULL;
    logic        want_hold  = 1'b0;
    logic        hold_taken;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned mismatch_count = 0;

    logic [7:0]  pending_bytes[$];
    line_frame_t expected_frames[$];
    line_frame_t want_frame;

    // Line scan state of the predictor
    logic [39:0] lead_chars;
    logic [2:0]  first_len;
    logic        seen_content;
    logic [2:0]  tok_count;
    logic        in_token;
    logic        tok_neg;
    logic        tok_digit;
    logic        tok_ended;
    logic        tok_ovf;
    logic [31:0] tok_mag;
    logic [31:0] nums[4];
    logic        nums_bad;

    ascii_status_line_parser_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line_stall   (line_stall),
        .line_byte    (line_byte),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_kind   (frame_kind),
        .value_first  (value_first),
        .value_second (value_second),
        .value_third  (value_third),
        .value_fourth (value_fourth)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------
    task automatic append_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic append_frame(input line_frame_t f);
        expected_frames.insert(expected_frames.size(), f);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_line();
        lead_chars   = '0;
        first_len    = '0;
        seen_content = 1'b0;
        tok_count    = '0;
        in_token     = 1'b0;
        tok_neg      = 1'b0;
        tok_digit    = 1'b0;
        tok_ended    = 1'b0;
        tok_ovf      = 1'b0;
        tok_mag      = '0;
        for (int i = 0; i < 4; i++)
        begin
            nums[i] = '0;
        end
        nums_bad     = 1'b0;
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return (c == asp_pkg::CHAR_SPACE) ||
               ((c >= asp_pkg::CHAR_TAB) && (c <= asp_pkg::CHAR_CR));
    endfunction

    function automatic logic first_starts(input string kw);
        if (first_len < kw.len())
            return 1'b0;
        for (int i = 0; i < kw.len(); i++)
        begin
            if (lead_chars[8*i +: 8] != kw[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Store the value of a number token, or mark the line as bad
    task automatic close_token();
        logic [2:0] slot;
        slot     = tok_count - 3'd1;
        in_token = 1'b0;
        if (slot >= 3'd1 && slot <= 3'd4)
        begin
            if (!tok_digit || tok_ovf)
                nums_bad = 1'b1;
            else if (tok_neg)
                nums[2'(slot - 3'd1)] = -tok_mag;
            else if (tok_mag > 32'h7FFF_FFFF)
                nums_bad = 1'b1;
            else
                nums[2'(slot - 3'd1)] = tok_mag;
        end
    endtask

    task automatic take_text_char(input logic [7:0] c);
        logic        fresh;
        logic [2:0]  slot;
        logic [35:0] grown;
        fresh = !in_token;
        if (fresh)
        begin
            in_token     = 1'b1;
            seen_content = 1'b1;
            if (tok_count < 3'd6)
                tok_count = tok_count + 3'd1;
            tok_neg   = 1'b0;
            tok_digit = 1'b0;
            tok_ended = 1'b0;
            tok_ovf   = 1'b0;
            tok_mag   = '0;
        end
        slot = tok_count - 3'd1;
        // Keep the head of the first token, scan tokens two to five as numbers
        if (slot == 3'd0)
        begin
            if (first_len < 3'd5)
                lead_chars[8*first_len +: 8] = c;
            if (first_len < 3'd7)
                first_len = first_len + 3'd1;
        end
        else if (slot <= 3'd4 && !tok_ended)
        begin
            if (c >= asp_pkg::CHAR_ZERO && c <= asp_pkg::CHAR_NINE)
            begin
                tok_digit = 1'b1;
                if (!tok_ovf)
                begin
                    grown = {4'b0, tok_mag} * 36'd10 + {28'b0, c - asp_pkg::CHAR_ZERO};
                    if (grown > 36'h0_8000_0000)
                        tok_ovf = 1'b1;
                    else
                        tok_mag = grown[31:0];
                end
            end
            else if (fresh && (c == asp_pkg::CHAR_PLUS || c == asp_pkg::CHAR_MINUS))
                tok_neg = (c == asp_pkg::CHAR_MINUS);
            else
                tok_ended = 1'b1;
        end
    endtask

    function automatic asp_pkg::kind_t line_kind();
        logic single;
        single = (tok_count == 3'd1);
        if (!seen_content)
            return asp_pkg::KIND_UNKNOWN;
        if (single && first_len == 3'd4 && first_starts("PONG"))
            return asp_pkg::KIND_PONG;
        if (single && first_len == 3'd4 && first_starts("BUSY"))
            return asp_pkg::KIND_BUSY;
        if (single && first_len == 3'd5 && first_starts("READY"))
            return asp_pkg::KIND_READY;
        if (first_starts("OK"))
            return asp_pkg::KIND_OK;
        if (first_starts("ERR"))
            return asp_pkg::KIND_ERROR;
        if (first_starts("ADC"))
            return asp_pkg::KIND_ADC;
        if (first_starts("POS"))
            return asp_pkg::KIND_POS;
        if (first_starts("LIM"))
            return asp_pkg::KIND_LIM;
        if (first_starts("DBG"))
            return asp_pkg::KIND_DBG;
        return asp_pkg::KIND_UNKNOWN;
    endfunction

    // Advance the line scan by one byte; a line feed yields one frame
    task automatic scan_status_byte(input logic [7:0] c);
        line_frame_t fr;
        logic        numeric;
        if (c != asp_pkg::CHAR_LF)
        begin
            if (is_blank(c))
            begin
                if (in_token)
                    close_token();
            end
            else
                take_text_char(c);
        end
        else
        begin
            if (in_token)
                close_token();
            fr.kind = line_kind();
            numeric = (fr.kind == asp_pkg::KIND_ADC) || (fr.kind == asp_pkg::KIND_POS) ||
                      (fr.kind == asp_pkg::KIND_LIM);
            if (numeric && (tok_count != 3'd5 || first_len != 3'd3 || nums_bad))
            begin
                fr.kind = asp_pkg::KIND_UNKNOWN;
                numeric = 1'b0;
            end
            for (int i = 0; i < 4; i++)
            begin
                fr.vals[i] = numeric ? nums[i] : 32'd0;
            end
            append_frame(fr);
            clear_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------
    function automatic logic sender_rests();
        case (pace)
            PACE_SEND_IDLE: return $urandom_range(0, 99) < 68;
            PACE_BOTH:      return $urandom_range(0, 99) < 25;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (pace)
            PACE_RECV_STALL: return $urandom_range(0, 99) < 68;
            PACE_BOTH:       return $urandom_range(0, 99) < 25;
            default:         return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict each accepted transaction, then offer the next byte
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid <= 1'b0;
            line_byte  <= 8'h00;
            clear_line();
        end
        else
        begin
            if (line_valid && !line_stall)
                scan_status_byte(line_byte);
            // Hold the payload while stalled
            if (!line_valid || !line_stall)
            begin
                if (pending_bytes.size() != 0 && !sender_rests())
                begin
                    line_valid <= 1'b1;
                    line_byte  <= pending_bytes.pop_front();
                end
                else
                    line_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted frame, drive the output stall
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_stall <= 1'b0;
            hold_taken  <= 1'b0;
            hold_left   <= 0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("frame_kind: expected no frame, actual %0d", frame_kind);
                    mismatch_count++;
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (frame_kind !== want_frame.kind)
                    begin
                        $error("frame_kind: expected %0d, actual %0d",
                               want_frame.kind, frame_kind);
                        mismatch_count++;
                    end
                    if (value_first !== want_frame.vals[0])
                    begin
                        $error("value_first: expected %0d, actual %0d",
                               $signed(want_frame.vals[0]), value_first);
                        mismatch_count++;
                    end
                    if (value_second !== want_frame.vals[1])
                    begin
                        $error("value_second: expected %0d, actual %0d",
                               $signed(want_frame.vals[1]), value_second);
                        mismatch_count++;
                    end
                    if (value_third !== want_frame.vals[2])
                    begin
                        $error("value_third: expected %0d, actual %0d",
                               $signed(want_frame.vals[2]), value_third);
                        mismatch_count++;
                    end
                    if (value_fourth !== want_frame.vals[3])
                    begin
                        $error("value_fourth: expected %0d, actual %0d",
                               $signed(want_frame.vals[3]), value_fourth);
                        mismatch_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the parser backs up
            if (want_hold && !hold_taken)
            begin
                hold_taken  <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                frame_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left   <= hold_left - 1;
                frame_stall <= 1'b1;
            end
            else
                frame_stall <= receiver_stalls();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((line_valid && !line_stall) || (frame_valid && !frame_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** ascii_status_line_parser_unit: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            append_byte(s[i]);
        end
    endtask

    task automatic add_line(input string s);
        add_text(s);
        append_byte(asp_pkg::CHAR_LF);
    endtask

    task automatic add_gap();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0:       append_byte(asp_pkg::CHAR_TAB);
                1:       append_byte(8'h0B);
                2:       append_byte(8'h0C);
                3:       append_byte(asp_pkg::CHAR_CR);
                default: append_byte(asp_pkg::CHAR_SPACE);
            endcase
        end
    endtask

    task automatic add_word();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            append_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // Append one number token: plain, extreme, overlong or malformed
    task automatic add_number();
        longint v;
        string  tok;
        int     n;
        v   = 0;
        tok = "";
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, 999);
            3, 4:    v = longint'(int'($urandom()));
            5:       v = -longint'($urandom_range(0, 99999));
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 64'sd2147483647;
                    1:       v = -64'sd2147483648;
                    2:       v = 64'sd2147483648;
                    default: v = -64'sd2147483649;
                endcase
            end
            7:
            begin
                n = $urandom_range(9, 13);
                if ($urandom_range(0, 1) == 1)
                    tok = "-";
                repeat (n)
                begin
                    tok = {tok, $sformatf("%0d", $urandom_range(0, 9))};
                end
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       tok = "-";
                    1:       tok = "+";
                    2:       tok = "+q";
                    default: tok = "--3";
                endcase
            end
            default: v = $urandom_range(0, 9);
        endcase
        if (tok.len() == 0)
        begin
            tok = $sformatf("%0d", v);
            if (v >= 0 && $urandom_range(0, 3) == 0)
                tok = {"+", tok};
        end
        if ($urandom_range(0, 7) == 0)
            tok = {tok, "x7"};
        add_text(tok);
    endtask

    task automatic add_random_line();
        int         shape;
        int         n;
        string      kw;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
            add_gap();
        shape = $urandom_range(0, 99);
        if (shape < 55)
        begin
            // Numeric frame, mostly well formed
            case ($urandom_range(0, 2))
                0:       kw = "ADC";
                1:       kw = "POS";
                default: kw = "LIM";
            endcase
            if ($urandom_range(0, 15) == 0)
                kw = {kw, "X"};
            add_text(kw);
            n = 4;
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(0, 7);
            repeat (n)
            begin
                add_gap();
                add_number();
            end
        end
        else if (shape < 80)
        begin
            case ($urandom_range(0, 5))
                0:       kw = "PONG";
                1:       kw = "BUSY";
                2:       kw = "READY";
                3:       kw = "OK";
                4:       kw = "ERR";
                default: kw = "DBG";
            endcase
            case ($urandom_range(0, 7))
                0:       kw = kw.substr(0, kw.len() - 2);
                1:       kw = {kw, "S"};
                default: ;
            endcase
            add_text(kw);
            if ($urandom_range(0, 2) == 0)
            begin
                add_gap();
                add_word();
            end
        end
        else
        begin
            // Noise over the whole byte range but the line feed
            n = $urandom_range(0, 12);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == asp_pkg::CHAR_LF)
                    b = 8'hFF;
                append_byte(b);
            end
        end
        if ($urandom_range(0, 3) == 0)
            add_gap();
        append_byte(asp_pkg::CHAR_LF);
    endtask

    task automatic add_directed_lines();
        add_line("");
        add_text(" ");
        append_byte(asp_pkg::CHAR_TAB);
        append_byte(8'h0B);
        append_byte(8'h0C);
        append_byte(asp_pkg::CHAR_CR);
        append_byte(asp_pkg::CHAR_LF);
        add_line("PONG");
        add_line("BUSY");
        add_line("READY");
        add_text("  READY ");
        append_byte(asp_pkg::CHAR_CR);
        append_byte(asp_pkg::CHAR_LF);
        add_line("PONG 1");
        add_line("PONGS");
        add_line("OK");
        add_line("OKAY done");
        add_line("ERR 5");
        add_line("ERRX");
        add_line("ADC 1 2 3 4");
        add_line("POS -2147483648 +2147483647 0 -0");
        add_line("LIM 2147483648 1 2 3");
        add_line("ADC 1 2 3 -2147483649");
        add_line("ADC 99999999999 1 1 1");
        add_line("ADCX 1 2 3 4");
        add_line("POS 1 2 3");
        add_line("LIM 1 2 3 4 5 6 7");
        add_line("ADC - 1 2 3");
        add_line("ADC +x abc 2 3");
        add_line("POS 12ab -7z 007 +5-3");
        add_line("DBG hello");
        add_line("DB");
        // Byte extremes inside the first token
        append_byte(8'h00);
        append_byte(8'h80);
        append_byte(8'hFF);
        append_byte(8'h7F);
        append_byte(asp_pkg::CHAR_LF);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, phases of stimulus, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int p = 0; p < 5; p++)
        begin
            @(negedge clk);
            pace = pace_t'(p);
            if (pace == PACE_HOLD)
                want_hold = 1'b1;
            if (p == 0)
                add_directed_lines();
            while (pending_bytes.size() < PHASE_BYTES)
                add_random_line();
            while (pending_bytes.size() != 0 || line_valid || expected_frames.size() != 0)
                @(negedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("** ascii_status_line_parser_unit: PASSED **");
        else
            $display("** ascii_status_line_parser_unit: FAILED **");
        $finish;
    end

endmodule
